// ----- sv/spq_pkg.sv -----
// spq_pkg: sizes, codes and shared types of the sorted priority queue
// used by spq_cell and sorted_priority_queue, depends on nothing
package spq_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic [IDX_W-1:0]              t_idx;
    typedef logic [CNT_W-1:0]              t_count;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_FIND   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_ABSENT = 2'd1,
        STATUS_FULL   = 2'd2
    } t_status;

    typedef struct packed {
        logic   ins;
        logic   rem;
        t_value key;
    } t_cell_ctl;

    typedef struct packed {
        logic below;
        logic first;
        logic eq;
    } t_cell_flags;

    function automatic t_value to_value(input logic signed [31:0] v);
        return VALUE_WIDTH'(v);
    endfunction

endpackage

// ----- sv/spq_cell.sv -----
// spq_cell: one slot of the sorted chain, compares against the key and
// shifts toward its neighbors; depends on spq_pkg
module spq_cell (
    input  logic                i_clk,
    input  spq_pkg::t_cell_ctl   i_ctl,
    input  logic                i_occupied,
    input  logic                i_left_before,
    input  spq_pkg::t_value      i_left_value,
    input  spq_pkg::t_value      i_right_value,
    output spq_pkg::t_cell_flags o_flags,
    output spq_pkg::t_value      o_value,
    output spq_pkg::t_value      o_next_value
);
    import spq_pkg::*;

    t_value r_value;
    t_value n_value;
    logic   below;
    logic   first;

    assign below = i_occupied && (r_value < i_ctl.key);
    assign first = !below && i_left_before;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (first) begin
                n_value = i_ctl.key;
            end else if (!below) begin
                n_value = i_left_value;
            end
        end else if (i_ctl.rem) begin
            if (!below) begin
                n_value = i_right_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_flags.below = below;
    assign o_flags.first = first;
    assign o_flags.eq    = i_occupied && (r_value == i_ctl.key);
    assign o_value       = r_value;
    assign o_next_value  = n_value;

endmodule

// ----- sv/sorted_priority_queue.sv -----
// sorted_priority_queue: bounded ascending queue built as a chain of cells
// instantiates spq_cell, depends on spq_pkg
//
//   channel   direction   handshake                   words
//   in        to block    i_in_valid / o_in_ready     i_kind, i_value
//   out       from block  o_out_valid / i_out_ready   o_status, o_position,
//                                                     o_head_valid, o_head_value,
//                                                     o_entry_count
//
// every cell compares with the key; cells from the insert or remove point on shift in the cycle the word is taken
// one word per cycle while the result register is empty or being drained
// the result appears in the cycle after acceptance, set by the result register
// reset empties the queue and the result register, entries hold no reset
// a held result stalls the input side through o_in_ready
module sorted_priority_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_kind,
    input  logic signed [31:0]    i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_status,
    output logic [3:0]            o_position,
    output logic                  o_head_valid,
    output logic signed [31:0]    o_head_value,
    output logic [spq_pkg::CNT_W-1:0] o_entry_count
);
    import spq_pkg::*;

    t_count      r_count;
    t_count      n_count;
    logic        r_out_valid;
    t_status     r_status;
    t_status     n_status;
    logic [3:0]  r_position;
    logic [3:0]  n_position;
    logic        r_head_valid;
    logic [31:0] r_head_value;
    logic [31:0] n_head_value;

    t_cell_ctl   ctl;
    t_cell_flags flags [DEPTH];
    t_value      value [DEPTH];
    t_value      next_value [DEPTH];
    logic [DEPTH-1:0] occupied;

    logic  accept;
    logic  full;
    logic  hit;
    t_idx  at;
    t_kind kind;

    assign kind       = t_kind'(i_kind);
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == t_count'(DEPTH));

    always_comb begin
        hit = 1'b0;
        at  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (flags[i].first) begin
                at  = at | t_idx'(i);
                hit = hit | flags[i].eq;
            end
        end
    end

    assign ctl.key = to_value(i_value);
    assign ctl.ins = accept && (kind == KIND_INSERT) && !full;
    assign ctl.rem = accept && (kind == KIND_REMOVE) && hit;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic   left_before;
            t_value left_value;
            t_value right_value;

            assign occupied[g] = (t_count'(g) < r_count);

            if (g == 0) begin : g_head
                assign left_before = 1'b1;
                assign left_value  = value[g];
            end else begin : g_mid
                assign left_before = flags[g-1].below;
                assign left_value  = value[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign right_value = value[g];
            end else begin : g_body
                assign right_value = value[g+1];
            end

            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (ctl),
                .i_occupied    (occupied[g]),
                .i_left_before (left_before),
                .i_left_value  (left_value),
                .i_right_value (right_value),
                .o_flags       (flags[g]),
                .o_value       (value[g]),
                .o_next_value  (next_value[g])
            );
        end
    endgenerate

    always_comb begin
        n_count    = r_count;
        n_status   = STATUS_ABSENT;
        n_position = '0;
        case (kind)
            KIND_INSERT: begin
                if (full) begin
                    n_status = STATUS_FULL;
                end else begin
                    n_status   = STATUS_OK;
                    n_position = 4'(at);
                    n_count    = r_count + t_count'(1);
                end
            end
            KIND_REMOVE: begin
                if (hit) begin
                    n_status   = STATUS_OK;
                    n_position = 4'(at);
                    n_count    = r_count - t_count'(1);
                end
            end
            KIND_FIND: begin
                if (hit) begin
                    n_status   = STATUS_OK;
                    n_position = 4'(at);
                end
            end
            default: begin
                n_status = STATUS_ABSENT;
            end
        endcase
        n_head_value = '0;
        if (n_count != '0) begin
            n_head_value = 32'($unsigned(next_value[0]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status     <= n_status;
            r_position   <= n_position;
            r_head_valid <= (n_count != '0);
            r_head_value <= n_head_value;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_position    = r_position;
    assign o_head_valid  = r_head_valid;
    assign o_head_value  = r_head_value;
    assign o_entry_count = r_count;

    logic [DEPTH-1:0] first_vec;
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            first_vec[i] = flags[i].first;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(DEPTH))
        else $error("entry count above depth");

    a_first_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(first_vec))
        else $error("more than one insert point");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.ins |=> r_count == $past(r_count) + t_count'(1))
        else $error("insert did not grow the queue");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.rem |=> r_count == $past(r_count) - t_count'(1))
        else $error("remove did not shrink the queue");

    a_head_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_head_valid == (r_count != '0)))
        else $error("head flag disagrees with count");

endmodule
